/* sv/ggx_pkg.sv */
// shared types, constants and pipeline depths for the ggx microfacet core
// no dependencies
package ggx_pkg;

  // fixed-point constants
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [15:0] ONE_Q15    = 16'h8000;
  localparam logic [26:0] INV_PI_Q28 = 27'd85445659;

  // iteration counts of the pipelined units
  localparam int NDF_QSTEPS  = 62;  // (a2 << 30) / t
  localparam int NDF_RSTEPS  = 34;  // (q << 16) / t, below saturation
  localparam int MASK_DSTEPS = 48;  // a2 * (1 - k) / m
  localparam int SQRT_STEPS  = 25;  // floor sqrt of a 50-bit word
  localparam int G1_STEPS    = 16;  // 2^31 / (sq + 1.0)

  // register stages from input word to result word of each unit
  localparam int NDF_LAT  = 2 + NDF_QSTEPS + 1 + NDF_RSTEPS + 2;
  localparam int MASK_LAT = 2 + MASK_DSTEPS + 1 + SQRT_STEPS + 1 + G1_STEPS;
  localparam int MASK_PAD = NDF_LAT - MASK_LAT;

  // accept edge to result strobe: squares stage, ndf unit, output register
  localparam int OUT_LAT = NDF_LAT + 2;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
    logic        sat;
  } ndf_res_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] g1;
  } mask_res_t;

endpackage

/* sv/ggx_ndf.sv */
// pipelined distribution term d = a2 / (pi * t^2) in q16.16 with saturation
// depends on ggx_pkg
module ggx_ndf import ggx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_a2,
  input  logic [30:0] in_c2,
  output ndf_res_t    res
);

  // product a2 * c2
  logic        s1_v_r;
  logic [31:0] s1_a2_r;
  logic [30:0] s1_c2_r;
  logic [62:0] s1_p_r;

  // first divider
  logic        qv_r   [NDF_QSTEPS+1];
  logic [31:0] qrem_r [NDF_QSTEPS+1];
  logic [61:0] qdq_r  [NDF_QSTEPS+1];
  logic [31:0] qt_r   [NDF_QSTEPS+1];
  logic        qz_r   [NDF_QSTEPS+1];
  logic [31:0] qrem_nxt [NDF_QSTEPS];
  logic [61:0] qdq_nxt  [NDF_QSTEPS];

  // second divider
  logic        rv_r   [NDF_RSTEPS+1];
  logic [31:0] rrem_r [NDF_RSTEPS+1];
  logic [33:0] rdq_r  [NDF_RSTEPS+1];
  logic [31:0] rt_r   [NDF_RSTEPS+1];
  logic        rs_r   [NDF_RSTEPS+1];
  logic [31:0] rrem_nxt [NDF_RSTEPS];
  logic [33:0] rdq_nxt  [NDF_RSTEPS];

  // scale by 1/pi
  logic        pv_r;
  logic        psat_r;
  logic [43:0] ph_r;
  logic [43:0] pl_r;

  logic [34:0] t_sum;
  logic [31:0] t_val;
  logic [43:0] q_hi;
  logic        r_sat;
  logic [60:0] p_sum;
  logic        p_over;
  logic        res_v_r;
  logic [31:0] res_value_r;
  logic        res_sat_r;

  assign t_sum  = {2'b0, s1_p_r[62:30]} + {4'b0, ONE_Q30 - s1_c2_r};
  assign t_val  = t_sum[31:0];
  assign q_hi   = qdq_r[NDF_QSTEPS][61:18];
  assign r_sat  = qz_r[NDF_QSTEPS] | (q_hi >= {12'b0, qt_r[NDF_QSTEPS]});
  assign p_sum  = {ph_r, 17'b0} + {17'b0, pl_r};
  assign p_over = p_sum[60];

  always_comb begin
    logic [32:0] sh;
    logic [32:0] df;
    logic        ge;
    for (int i = 0; i < NDF_QSTEPS; i++) begin
      sh = {qrem_r[i], qdq_r[i][61]};
      df = sh - {1'b0, qt_r[i]};
      ge = (sh >= {1'b0, qt_r[i]});
      qrem_nxt[i] = ge ? df[31:0] : sh[31:0];
      qdq_nxt[i]  = {qdq_r[i][60:0], ge};
    end
  end

  always_comb begin
    logic [32:0] sh;
    logic [32:0] df;
    logic        ge;
    for (int i = 0; i < NDF_RSTEPS; i++) begin
      sh = {rrem_r[i], rdq_r[i][33]};
      df = sh - {1'b0, rt_r[i]};
      ge = (sh >= {1'b0, rt_r[i]});
      rrem_nxt[i] = ge ? df[31:0] : sh[31:0];
      rdq_nxt[i]  = {rdq_r[i][32:0], ge};
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      for (int i = 0; i <= NDF_QSTEPS; i++) qv_r[i] <= 1'b0;
      for (int i = 0; i <= NDF_RSTEPS; i++) rv_r[i] <= 1'b0;
      pv_r    <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      s1_v_r  <= in_valid;
      qv_r[0] <= s1_v_r;
      for (int i = 0; i < NDF_QSTEPS; i++) qv_r[i+1] <= qv_r[i];
      rv_r[0] <= qv_r[NDF_QSTEPS];
      for (int i = 0; i < NDF_RSTEPS; i++) rv_r[i+1] <= rv_r[i];
      pv_r    <= rv_r[NDF_RSTEPS];
      res_v_r <= pv_r;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    s1_a2_r <= in_a2;
    s1_c2_r <= in_c2;
    s1_p_r  <= {31'b0, in_a2} * {32'b0, in_c2};

    qrem_r[0] <= '0;
    qdq_r[0]  <= {s1_a2_r, 30'b0};
    qt_r[0]   <= t_val;
    qz_r[0]   <= (t_val == '0);
    for (int i = 0; i < NDF_QSTEPS; i++) begin
      qrem_r[i+1] <= qrem_nxt[i];
      qdq_r[i+1]  <= qdq_nxt[i];
      qt_r[i+1]   <= qt_r[i];
      qz_r[i+1]   <= qz_r[i];
    end

    // high part of q is below t unless saturated, so it seeds the remainder
    rrem_r[0] <= q_hi[31:0];
    rdq_r[0]  <= {qdq_r[NDF_QSTEPS][17:0], 16'b0};
    rt_r[0]   <= qt_r[NDF_QSTEPS];
    rs_r[0]   <= r_sat;
    for (int i = 0; i < NDF_RSTEPS; i++) begin
      rrem_r[i+1] <= rrem_nxt[i];
      rdq_r[i+1]  <= rdq_nxt[i];
      rt_r[i+1]   <= rt_r[i];
      rs_r[i+1]   <= rs_r[i];
    end

    ph_r   <= {27'b0, rdq_r[NDF_RSTEPS][33:17]} * {17'b0, INV_PI_Q28};
    pl_r   <= {27'b0, rdq_r[NDF_RSTEPS][16:0]} * {17'b0, INV_PI_Q28};
    psat_r <= rs_r[NDF_RSTEPS];

    res_sat_r   <= psat_r | p_over;
    res_value_r <= (psat_r | p_over) ? '1 : p_sum[59:28];
  end

  assign res = {res_v_r, res_value_r, res_sat_r};

endmodule

/* sv/ggx_mask.sv */
// pipelined smith g1 term 2 / (sqrt(1 + a2 tan2) + 1) in q1.15
// depends on ggx_pkg
module ggx_mask import ggx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_a2,
  input  logic [30:0] in_c2,
  input  logic [15:0] in_lo,
  output mask_res_t   res
);

  logic        s1_v_r;
  logic [47:0] s1_num_r;
  logic [15:0] s1_m_r;

  logic        dv_r   [MASK_DSTEPS+1];
  logic [15:0] drem_r [MASK_DSTEPS+1];
  logic [47:0] ddq_r  [MASK_DSTEPS+1];
  logic [15:0] dm_r   [MASK_DSTEPS+1];
  logic [15:0] drem_nxt [MASK_DSTEPS];
  logic [47:0] ddq_nxt  [MASK_DSTEPS];

  logic        sv_r    [SQRT_STEPS+1];
  logic [26:0] srem_r  [SQRT_STEPS+1];
  logic [24:0] sroot_r [SQRT_STEPS+1];
  logic [49:0] srest_r [SQRT_STEPS+1];
  logic [26:0] srem_nxt  [SQRT_STEPS];
  logic [24:0] sroot_nxt [SQRT_STEPS];

  logic        gv_r   [G1_STEPS+1];
  logic [25:0] grem_r [G1_STEPS+1];
  logic [15:0] gq_r   [G1_STEPS+1];
  logic [25:0] gd_r   [G1_STEPS+1];
  logic [25:0] grem_nxt [G1_STEPS];
  logic [15:0] gq_nxt   [G1_STEPS];

  logic [15:0] k;
  logic [15:0] m;
  logic [15:0] dif;
  logic [48:0] s_val;
  logic [25:0] d_val;

  assign k     = in_c2[30:15];
  assign m     = (k > in_lo) ? k : in_lo;
  assign dif   = ONE_Q15 - k;
  assign s_val = {1'b0, ddq_r[MASK_DSTEPS]} + {18'b0, ONE_Q30};
  assign d_val = {1'b0, sroot_r[SQRT_STEPS]} + {10'b0, ONE_Q15};

  always_comb begin
    logic [16:0] sh;
    logic [16:0] df;
    logic        ge;
    for (int i = 0; i < MASK_DSTEPS; i++) begin
      sh = {drem_r[i], ddq_r[i][47]};
      df = sh - {1'b0, dm_r[i]};
      ge = (sh >= {1'b0, dm_r[i]});
      drem_nxt[i] = ge ? df[15:0] : sh[15:0];
      ddq_nxt[i]  = {ddq_r[i][46:0], ge};
    end
  end

  // one root bit per step from two radicand bits
  always_comb begin
    logic [28:0] sh;
    logic [28:0] tr;
    logic [28:0] df;
    logic        ge;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      sh = {srem_r[i], srest_r[i][49:48]};
      tr = {2'b0, sroot_r[i], 2'b01};
      df = sh - tr;
      ge = (sh >= tr);
      srem_nxt[i]  = ge ? df[26:0] : sh[26:0];
      sroot_nxt[i] = {sroot_r[i][23:0], ge};
    end
  end

  always_comb begin
    logic [26:0] sh;
    logic [26:0] df;
    logic        ge;
    for (int i = 0; i < G1_STEPS; i++) begin
      sh = {grem_r[i], 1'b0};
      df = sh - {1'b0, gd_r[i]};
      ge = (sh >= {1'b0, gd_r[i]});
      grem_nxt[i] = ge ? df[25:0] : sh[25:0];
      gq_nxt[i]   = {gq_r[i][14:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      for (int i = 0; i <= MASK_DSTEPS; i++) dv_r[i] <= 1'b0;
      for (int i = 0; i <= SQRT_STEPS; i++) sv_r[i] <= 1'b0;
      for (int i = 0; i <= G1_STEPS; i++) gv_r[i] <= 1'b0;
    end else begin
      s1_v_r  <= in_valid;
      dv_r[0] <= s1_v_r;
      for (int i = 0; i < MASK_DSTEPS; i++) dv_r[i+1] <= dv_r[i];
      sv_r[0] <= dv_r[MASK_DSTEPS];
      for (int i = 0; i < SQRT_STEPS; i++) sv_r[i+1] <= sv_r[i];
      gv_r[0] <= sv_r[SQRT_STEPS];
      for (int i = 0; i < G1_STEPS; i++) gv_r[i+1] <= gv_r[i];
    end
  end

  always_ff @(posedge clk) begin
    s1_num_r <= {16'b0, in_a2} * {32'b0, dif};
    s1_m_r   <= m;

    drem_r[0] <= '0;
    ddq_r[0]  <= s1_num_r;
    dm_r[0]   <= s1_m_r;
    for (int i = 0; i < MASK_DSTEPS; i++) begin
      drem_r[i+1] <= drem_nxt[i];
      ddq_r[i+1]  <= ddq_nxt[i];
      dm_r[i+1]   <= dm_r[i];
    end

    srem_r[0]  <= '0;
    sroot_r[0] <= '0;
    srest_r[0] <= {1'b0, s_val};
    for (int i = 0; i < SQRT_STEPS; i++) begin
      srem_r[i+1]  <= srem_nxt[i];
      sroot_r[i+1] <= sroot_nxt[i];
      srest_r[i+1] <= {srest_r[i][47:0], 2'b00};
    end

    // 2^31 >> 16 seeds the remainder, the dividend tail is all zero
    grem_r[0] <= {10'b0, ONE_Q15};
    gq_r[0]   <= '0;
    gd_r[0]   <= d_val;
    for (int i = 0; i < G1_STEPS; i++) begin
      grem_r[i+1] <= grem_nxt[i];
      gq_r[i+1]   <= gq_nxt[i];
      gd_r[i+1]   <= gd_r[i];
    end
  end

  assign res.valid = gv_r[G1_STEPS];
  assign res.g1    = gq_r[G1_STEPS];

endmodule

/* sv/ggx_distribution_and_masking_core.sv */
// top level of the ggx microfacet core: squares, ndf and masking pipelines, output word
// depends on ggx_pkg, ggx_ndf and ggx_mask
//
// One word enters per clock: a word is taken at every rising edge with start high and
// busy low, and busy is low at all times after reset, so a new word can follow every
// cycle. Each word gives exactly one result word, passing the squares stage, the ndf unit
// and the output register, shown on the out_ ports for one cycle with out_strobe high;
// words come out in order and the receiver has no way to hold them, so it must take each
// one. The delay is set by the distribution path, which runs two long divisions one
// quotient bit per stage (62 and 34 stages); the masking path (divider, square root,
// reciprocal) is shorter and is delayed to meet it. cfg_min_cos_sqr is written with
// cfg_we and must only change while no word is in flight.
module ggx_distribution_and_masking_core import ggx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_cos_half,
  input  logic [15:0] in_cos_in,
  input  logic [15:0] in_cos_out,
  input  logic [15:0] in_roughness,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_strobe,
  output logic [31:0] out_ndf_value,
  output logic [15:0] out_masking_value,
  output logic        out_ndf_saturated
);

  logic        busy_r;
  logic [15:0] cfg_min_cos_sqr_r;
  logic        accept;

  // squares stage
  logic        sq_v_r;
  logic [31:0] a2_r;
  logic [30:0] ch2_r;
  logic [30:0] ci2_r;
  logic [30:0] co2_r;
  logic signed [31:0] ch_sq;
  logic signed [31:0] ci_sq;
  logic signed [31:0] co_sq;
  logic [15:0] clamp_lo;

  ndf_res_t    ndf_res;
  mask_res_t   mask_in_res;
  mask_res_t   mask_out_res;

  // delay line aligning the masking path with the distribution path
  logic        pad_v_r  [MASK_PAD];
  logic [15:0] pad_gi_r [MASK_PAD];
  logic [15:0] pad_go_r [MASK_PAD];
  logic [31:0] g_prod;

  logic        out_strobe_r;
  logic [31:0] out_ndf_value_r;
  logic [15:0] out_masking_value_r;
  logic        out_ndf_saturated_r;

  assign accept = start & ~busy_r;

  // sign drops out of the squares
  assign ch_sq = $signed(in_cos_half) * $signed(in_cos_half);
  assign ci_sq = $signed(in_cos_in) * $signed(in_cos_in);
  assign co_sq = $signed(in_cos_out) * $signed(in_cos_out);

  // a zero clamp acts as the smallest step
  assign clamp_lo = (cfg_min_cos_sqr_r == '0) ? 16'd1 : cfg_min_cos_sqr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r            <= 1'b1;
      cfg_min_cos_sqr_r <= 16'd1;
      sq_v_r            <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      sq_v_r <= accept;
      if (cfg_we) begin
        cfg_min_cos_sqr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    a2_r  <= {16'b0, in_roughness} * {16'b0, in_roughness};
    ch2_r <= ch_sq[30:0];
    ci2_r <= ci_sq[30:0];
    co2_r <= co_sq[30:0];
  end

  ggx_ndf u_ndf (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sq_v_r),
    .in_a2    (a2_r),
    .in_c2    (ch2_r),
    .res      (ndf_res)
  );

  ggx_mask u_mask_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sq_v_r),
    .in_a2    (a2_r),
    .in_c2    (ci2_r),
    .in_lo    (clamp_lo),
    .res      (mask_in_res)
  );

  ggx_mask u_mask_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sq_v_r),
    .in_a2    (a2_r),
    .in_c2    (co2_r),
    .in_lo    (clamp_lo),
    .res      (mask_out_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MASK_PAD; i++) pad_v_r[i] <= 1'b0;
    end else begin
      pad_v_r[0] <= mask_in_res.valid;
      for (int i = 1; i < MASK_PAD; i++) pad_v_r[i] <= pad_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    pad_gi_r[0] <= mask_in_res.g1;
    pad_go_r[0] <= mask_out_res.g1;
    for (int i = 1; i < MASK_PAD; i++) begin
      pad_gi_r[i] <= pad_gi_r[i-1];
      pad_go_r[i] <= pad_go_r[i-1];
    end
  end

  // g = g1(in) * g1(out) in q1.15, at most 1.0
  assign g_prod = {16'b0, pad_gi_r[MASK_PAD-1]} * {16'b0, pad_go_r[MASK_PAD-1]};

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ndf_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ndf_value_r     <= ndf_res.value;
    out_ndf_saturated_r <= ndf_res.sat;
    out_masking_value_r <= g_prod[30:15];
  end

  assign busy              = busy_r;
  assign out_strobe        = out_strobe_r;
  assign out_ndf_value     = out_ndf_value_r;
  assign out_masking_value = out_masking_value_r;
  assign out_ndf_saturated = out_ndf_saturated_r;

  // both paths must deliver the same word in the same cycle
  a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    ndf_res.valid == pad_v_r[MASK_PAD-1])
    else $error("ndf and masking paths out of step");

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##OUT_LAT out_strobe)
    else $error("result word missing after pipeline latency");

  // a saturated distribution reads as all ones
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_ndf_saturated |-> out_ndf_value == 32'hFFFF_FFFF)
    else $error("saturated ndf not clamped");

  // masking never exceeds one
  a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_masking_value <= ONE_Q15)
    else $error("masking above one");

endmodule

/* tb/sv/ggx_checker.sv */
`timescale 1ns / 1ps
// result checker for the ggx microfacet core: predicts each result word and compares
// depends on the core's port list only (watches start/busy, in_, cfg and out_ channels)
module ggx_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_cos_half,
  input  logic [15:0] in_cos_in,
  input  logic [15:0] in_cos_out,
  input  logic [15:0] in_roughness,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        out_strobe,
  input  logic [31:0] out_ndf_value,
  input  logic [15:0] out_masking_value,
  input  logic        out_ndf_saturated,
  output int          fail_count,
  output int          words_pending
);

  typedef struct packed {
    logic [31:0] ndf;
    logic [15:0] mask;
    logic        sat;
  } shade_t;

  localparam bit [63:0] Q30       = 64'd1 << 30;
  localparam bit [63:0] Q15       = 64'd32768;
  localparam bit [63:0] INV_PI    = 64'd85445659;
  localparam bit [63:0] RATIO_MAX = 64'd1 << 34;
  localparam bit [63:0] NDF_TOP   = 64'hFFFF_FFFF;

  bit [15:0] clamp_reg;
  shade_t    shade_q[$];

  function automatic bit [63:0] cos_sq(bit [15:0] raw);
    longint c;
    c = longint'($signed(raw));
    return 64'(c * c);
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // smith g1 for one direction
  function automatic bit [63:0] g1_term(bit [63:0] c2, bit [63:0] a2);
    bit [63:0] k;
    bit [63:0] lo;
    bit [63:0] m;
    bit [63:0] s;
    k  = c2 >> 15;
    lo = (clamp_reg == 0) ? 64'd1 : 64'(clamp_reg);
    m  = (k > lo) ? k : lo;
    s  = Q30 + (a2 * (Q15 - k)) / m;
    return (64'd1 << 31) / (floor_sqrt(s) + Q15);
  endfunction

  function automatic shade_t shade_word(bit [15:0] ch, bit [15:0] ci, bit [15:0] co,
                                        bit [15:0] rough);
    shade_t    w;
    bit [63:0] a2;
    bit [63:0] ch2;
    bit [63:0] t;
    bit [63:0] q;
    bit [63:0] r;
    bit [63:0] d;
    a2  = 64'(rough) * 64'(rough);
    ch2 = cos_sq(ch);
    t   = (a2 * ch2 + Q30 * (Q30 - ch2)) >> 30;
    w.sat = 1'b0;
    if (t == 0) begin
      d = NDF_TOP;
      w.sat = 1'b1;
    end else begin
      q = (a2 << 30) / t;
      r = (q << 16) / t;
      if (r >= RATIO_MAX) begin
        d = NDF_TOP;
        w.sat = 1'b1;
      end else begin
        d = (r * INV_PI) >> 28;
        if (d > NDF_TOP) begin
          d = NDF_TOP;
          w.sat = 1'b1;
        end
      end
    end
    w.ndf  = d[31:0];
    w.mask = 16'((g1_term(cos_sq(ci), a2) * g1_term(cos_sq(co), a2)) >> 15);
    return w;
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    words_pending = 0;
  end

  always @(posedge clk) begin
    shade_t want;
    if (!rst_n) begin
      clamp_reg = 16'd1;
    end else begin
      if (cfg_we) clamp_reg = cfg_wdata;
      if (start && !busy)
        shade_q.push_back(shade_word(in_cos_half, in_cos_in, in_cos_out, in_roughness));
      if (out_strobe) begin
        if (shade_q.size() == 0) begin
          $display("unexpected result word at %0t", $realtime);
          fail_count++;
        end else begin
          want = shade_q.pop_front();
          if (out_ndf_value !== want.ndf) report("ndf_value", out_ndf_value, want.ndf);
          if (out_masking_value !== want.mask)
            report("masking_value", out_masking_value, want.mask);
          if (out_ndf_saturated !== want.sat)
            report("ndf_saturated", out_ndf_saturated, want.sat);
        end
      end
      words_pending = shade_q.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// top of the ggx core testbench: clock, reset, stimulus and verdict
// depends on ggx_distribution_and_masking_core and ggx_checker
module testbench;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_cos_half;
  logic [15:0] in_cos_in;
  logic [15:0] in_cos_out;
  logic [15:0] in_roughness;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        out_strobe;
  logic [31:0] out_ndf_value;
  logic [15:0] out_masking_value;
  logic        out_ndf_saturated;
  int          fail_count;
  int          words_pending;

  ggx_distribution_and_masking_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cos_half      (in_cos_half),
    .in_cos_in        (in_cos_in),
    .in_cos_out       (in_cos_out),
    .in_roughness     (in_roughness),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_ndf_value    (out_ndf_value),
    .out_masking_value(out_masking_value),
    .out_ndf_saturated(out_ndf_saturated)
  );

  ggx_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cos_half      (in_cos_half),
    .in_cos_in        (in_cos_in),
    .in_cos_out       (in_cos_out),
    .in_roughness     (in_roughness),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_ndf_value    (out_ndf_value),
    .out_masking_value(out_masking_value),
    .out_ndf_saturated(out_ndf_saturated),
    .fail_count       (fail_count),
    .words_pending    (words_pending)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

  // burst bookkeeping for the sender
  int burst_left;

  // present one word and hold it until the core takes it; start stays high
  // so the next word of a burst follows back to back
  task automatic send_word(logic [15:0] ch, logic [15:0] ci, logic [15:0] co,
                           logic [15:0] rough);
    start        <= 1'b1;
    in_cos_half  <= ch;
    in_cos_in    <= ci;
    in_cos_out   <= co;
    in_roughness <= rough;
    do @(posedge clk); while (busy);
    // end of burst: drop start and idle for a random gap
    if (burst_left == 0) begin
      start <= 1'b0;
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // register write only with the pipe drained
  task automatic write_clamp(logic [15:0] v);
    start <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (110) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // random cosine: full range, or close to the +-1 ends, or close to zero
  function automatic logic [15:0] pick_cos();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return 16'(32767 - $urandom_range(0, 300));
    if (sel == 1) return 16'(-32768 + $urandom_range(0, 300));
    if (sel == 2) return 16'($signed(17'($urandom_range(0, 600)) - 17'd300));
    return 16'($urandom);
  endfunction

  // random roughness: mostly full range, some very smooth, some close to one
  function automatic logic [15:0] pick_rough();
    int unsigned sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return 16'($urandom_range(1, 80));
    if (sel == 1) return 16'(32768 - $urandom_range(0, 40));
    return 16'($urandom_range(1, 32768));
  endfunction

  logic [15:0] clamp_set [6];

  initial begin
    // every input known from time zero
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cos_half  = '0;
    in_cos_in    = '0;
    in_cos_out   = '0;
    in_roughness = 16'd1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    burst_left   = 4;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words with the reset clamp
    // cosine at -1 with tiny roughness: ratio beyond range, ndf saturates
    send_word(16'h8000, 16'h8000, 16'h8000, 16'd1);
    send_word(16'h8000, 16'h7FFF, 16'h0000, 16'd64);
    send_word(16'h8000, 16'h0001, 16'hFFFF, 16'd65);
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd32768);
    send_word(16'h0000, 16'h0000, 16'h0000, 16'd32768);
    send_word(16'h0000, 16'h0000, 16'h0000, 16'd1);
    send_word(16'h7FFF, 16'h8001, 16'h0001, 16'd1);
    // sign is dropped: these two words must match
    send_word(16'h4000, 16'h2000, 16'h6000, 16'd16384);
    send_word(16'hC000, 16'hE000, 16'hA000, 16'd16384);
    send_word(16'h5A82, 16'h5A82, 16'hA57E, 16'd32767);
    send_word(16'h0001, 16'hFFFF, 16'h8000, 16'd2);
    send_word(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_word(16'h5555, 16'hAAAA, 16'h5555, 16'h2AAA);
    send_word(16'h7FFF, 16'h0000, 16'h7FFF, 16'd256);

    // clamp settings: extremes first, then random
    clamp_set[0] = 16'd32768;
    clamp_set[1] = 16'd1;
    clamp_set[2] = 16'(($urandom_range(1, 32767)) | 16'h7FFF);
    clamp_set[3] = 16'($urandom_range(1, 64));
    clamp_set[4] = 16'($urandom_range(1, 32768));
    clamp_set[5] = 16'($urandom_range(256, 4096));

    foreach (clamp_set[p]) begin
      write_clamp(clamp_set[p]);
      // a few extremes under each clamp, then random words
      send_word(16'h0000, 16'h0000, 16'h8000, 16'd32768);
      send_word(16'h7FFF, 16'h0001, 16'h7FFF, 16'd1);
      repeat (322) send_word(pick_cos(), pick_cos(), pick_cos(), pick_rough());
    end

    // drain, then let the pipe settle
    start <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
